>>> rtl/point_transform_perspective_defines.svh
// Assertion macros for the point transform block.
// Depends on nothing; included by the top level only.
`ifndef POINT_TRANSFORM_PERSPECTIVE_DEFINES_SVH
`define POINT_TRANSFORM_PERSPECTIVE_DEFINES_SVH
`ifndef SYNTH
// Check an implication that holds in the same cycle.
`define PTP_ASSERT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Check an implication that holds in the next cycle.
`define PTP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define PTP_ASSERT(lbl, clk, rst_n, ante, cons)
`define PTP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/ptp_pkg.sv
// Package for the point transform block: widths, stage types, divide step.
// Used by the top level.
`default_nettype none
package ptp_pkg;
    localparam int FRAC_BITS = 16;
    localparam int MAG_W     = 64;                 // column sum magnitude
    localparam int NUM_W     = MAG_W + FRAC_BITS;  // scaled dividend
    localparam int QB_W      = 33;                 // quotient bits kept
    localparam int CMP_W     = MAG_W + QB_W + 1;   // divisor shifted by QB_W
    localparam int SUM_W     = 66;                 // signed column sum
    localparam int N_STEP    = QB_W + 1;           // overflow step plus quotient bits
    localparam logic [31:0] ONE = 32'(64'd1 << FRAC_BITS);

    typedef struct packed {
        logic [NUM_W-1:0] rem;
        logic [QB_W-1:0]  q;
        logic             neg;
        logic             big;
    } t_lane;

    typedef struct packed {
        t_lane [2:0]      lane;
        logic [MAG_W-1:0] den;
        logic             wz;
    } t_div;

    // One restoring step at quotient weight k; weight QB_W only flags overflow.
    function automatic t_lane div_step(t_lane l, logic [MAG_W-1:0] den, int k);
        t_lane            o;
        logic [CMP_W-1:0] sh;
        logic [CMP_W-1:0] rx;
        o  = l;
        sh = CMP_W'(den) << k;
        rx = CMP_W'(l.rem);
        if (!l.big && rx >= sh) begin
            if (k == QB_W) begin
                o.big = 1'b1;
            end else begin
                o.rem  = NUM_W'(rx - sh);
                o.q[k] = 1'b1;
            end
        end
        return o;
    endfunction
endpackage
`default_nettype wire

>>> rtl/ptp_if.sv
// Valid/ready channel interfaces for input and result transactions.
// Depends on nothing.
`default_nettype none
interface ptp_in_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [3:0]  entry_index;
    logic signed [31:0] entry_value;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    modport source (output valid, func, entry_index, entry_value, point_x, point_y,
                    point_z, input ready);
    modport sink (input valid, func, entry_index, entry_value, point_x, point_y,
                  point_z, output ready);
endinterface

interface ptp_out_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic        w_zero_error;
    modport source (output valid, out_x, out_y, out_z, w_zero_error, input ready);
    modport sink (input valid, out_x, out_y, out_z, w_zero_error, output ready);
endinterface
`default_nettype wire

>>> rtl/point_transform_perspective.sv
// Top level of the point transform block: matrix store, multiply, sum and divide pipeline.
// Depends on ptp_pkg, ptp_if and point_transform_perspective_defines.svh.
`default_nettype none
`include "point_transform_perspective_defines.svh"
// Homogeneous vertex transform. A load transaction (func = 0) writes one Q16.16 entry of the
// 4x4 matrix, row*4 + column, and gives no result; the write is visible to the very next
// transaction. A transform transaction (func = 1) multiplies (x, y, z, 1) by the matrix and
// divides x, y, z by w, giving one result with quotients truncated toward zero and saturated.
// A zero w gives zeros and raises w_zero_error. Stages: one multiply, one sum and one
// magnitude stage, 34 restoring divide steps (the first flags overflow, each later one
// gives one quotient bit; three lanes share the divisor) and the output register. The
// whole pipeline holds while a result waits on the output, so one transform enters per
// clock (one item per cycle) whenever the sink is ready. The matrix resets to identity.
module point_transform_perspective (
    input  wire        i_clk,
    input  wire        i_rst_n,
    ptp_in_if.sink     i_in,
    ptp_out_if.source  o_out
);
    localparam int LAST = ptp_pkg::N_STEP - 1;

    logic [31:0] r_mat [16];
    logic        adv;

    // stage 1: products
    logic               r_v1;
    logic signed [63:0] r_prod [3][4];
    logic signed [31:0] r_row3 [4];
    // stage 2: column sums
    logic                           r_v2;
    logic signed [ptp_pkg::SUM_W-1:0] r_sum [4];
    // stage 3: dividend setup
    logic            r_v3;
    ptp_pkg::t_div   r_d3;
    ptp_pkg::t_div   n_d3;
    // divide steps
    logic            r_vd [ptp_pkg::N_STEP];
    ptp_pkg::t_div   r_dv [ptp_pkg::N_STEP];
    // output
    logic            r_ov;
    logic [31:0]     r_ox, r_oy, r_oz;
    logic            r_owz;
    logic [31:0]     n_o [3];

    // hold everything while a result waits
    assign adv        = !r_ov || o_out.ready;
    assign i_in.ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 16; i++) begin
                r_mat[i] <= ((i % 5) == 0) ? ptp_pkg::ONE : 32'd0;
            end
        end else if (i_in.valid && adv && !i_in.func) begin
            r_mat[i_in.entry_index] <= i_in.entry_value;
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_ov <= 1'b0;
            for (int i = 0; i < ptp_pkg::N_STEP; i++) r_vd[i] <= 1'b0;
        end else if (adv) begin
            r_v1 <= i_in.valid && i_in.func;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_vd[0] <= r_v3;
            for (int i = 1; i < ptp_pkg::N_STEP; i++) r_vd[i] <= r_vd[i-1];
            r_ov <= r_vd[LAST];
        end
    end

    // multiply: one product per register path
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int j = 0; j < 4; j++) begin
                r_prod[0][j] <= i_in.point_x * $signed(r_mat[j]);
                r_prod[1][j] <= i_in.point_y * $signed(r_mat[4 + j]);
                r_prod[2][j] <= i_in.point_z * $signed(r_mat[8 + j]);
                r_row3[j]    <= $signed(r_mat[12 + j]);
            end
        end
    end

    // sum the column, fourth row scaled to product precision
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int j = 0; j < 4; j++) begin
                r_sum[j] <= ptp_pkg::SUM_W'(r_prod[0][j]) + ptp_pkg::SUM_W'(r_prod[1][j])
                          + ptp_pkg::SUM_W'(r_prod[2][j])
                          + (ptp_pkg::SUM_W'(r_row3[j]) <<< ptp_pkg::FRAC_BITS);
            end
        end
    end

    // magnitudes, signs and scaled dividends
    always_comb begin
        logic [ptp_pkg::SUM_W-1:0] a;
        logic                      wneg;
        wneg       = r_sum[3][ptp_pkg::SUM_W-1];
        a          = wneg ? -r_sum[3] : r_sum[3];
        n_d3.den   = a[ptp_pkg::MAG_W-1:0];
        n_d3.wz    = (r_sum[3] == '0);
        for (int j = 0; j < 3; j++) begin
            a = r_sum[j][ptp_pkg::SUM_W-1] ? -r_sum[j] : r_sum[j];
            n_d3.lane[j].rem = ptp_pkg::NUM_W'(a[ptp_pkg::MAG_W-1:0]) << ptp_pkg::FRAC_BITS;
            n_d3.lane[j].q   = '0;
            n_d3.lane[j].neg = r_sum[j][ptp_pkg::SUM_W-1] ^ wneg;
            // a zero divisor would flag overflow; the result is replaced anyway
            n_d3.lane[j].big = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) r_d3 <= n_d3;
    end

    // restoring divide, an overflow step then one quotient bit per stage
    for (genvar s = 0; s < ptp_pkg::N_STEP; s++) begin : g_div
        ptp_pkg::t_div src;
        ptp_pkg::t_div n_dv;
        if (s == 0) begin : g_first
            assign src = r_d3;
        end else begin : g_rest
            assign src = r_dv[s-1];
        end
        always_comb begin
            n_dv = src;
            for (int l = 0; l < 3; l++) begin
                n_dv.lane[l] = ptp_pkg::div_step(src.lane[l], src.den, ptp_pkg::QB_W - s);
            end
        end
        always_ff @(posedge i_clk) begin
            if (adv) r_dv[s] <= n_dv;
        end
    end

    // saturate and apply sign
    always_comb begin
        logic [ptp_pkg::QB_W-1:0] lim;
        logic [ptp_pkg::QB_W-1:0] q;
        for (int l = 0; l < 3; l++) begin
            lim = r_dv[LAST].lane[l].neg ? ptp_pkg::QB_W'(33'h080000000)
                                         : ptp_pkg::QB_W'(33'h07FFFFFFF);
            q   = r_dv[LAST].lane[l].q;
            if (r_dv[LAST].lane[l].big || q > lim) q = lim;
            n_o[l] = r_dv[LAST].lane[l].neg ? -q[31:0] : q[31:0];
            if (r_dv[LAST].wz) n_o[l] = 32'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_ox  <= n_o[0];
            r_oy  <= n_o[1];
            r_oz  <= n_o[2];
            r_owz <= r_dv[LAST].wz;
        end
    end

    assign o_out.valid        = r_ov;
    assign o_out.out_x        = r_ox;
    assign o_out.out_y        = r_oy;
    assign o_out.out_z        = r_oz;
    assign o_out.w_zero_error = r_owz;

    // zero w gives zero coordinates
    `PTP_ASSERT(a_wz_zero, i_clk, i_rst_n, r_ov && r_owz, r_ox == 0 && r_oy == 0 && r_oz == 0)
    // a load lands in the store on the next cycle
    `PTP_ASSERT_NEXT(a_load, i_clk, i_rst_n, i_in.valid && adv && !i_in.func, r_mat[$past(i_in.entry_index)] == $past(i_in.entry_value))
    // a stalled result holds
    `PTP_ASSERT_NEXT(a_hold, i_clk, i_rst_n, r_ov && !o_out.ready, r_ov && $stable(r_ox) && $stable(r_owz))
endmodule
`default_nettype wire
